// File: rtl/mac_address_text_parser_macros.svh
// Assertion macros shared by the MAC address text parser modules.
`ifndef MAC_ADDRESS_TEXT_PARSER_MACROS_SVH
`define MAC_ADDRESS_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, clocked on aclk and held off during reset.
`define MAT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and held off during reset.
`define MAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mat_pkg.sv
// Types and constants of the MAC address text parser.
package mat_pkg;

    localparam int CHAR_W       = 8;
    localparam int ADDR_W       = 48;
    localparam int NIB_W        = 4;
    localparam int GCNT_W       = 4;
    localparam int TCNT_W       = 5;
    localparam int NIBBLE_LIMIT = 12;
    localparam int COUNT_SAT    = 13;

    // Setting this bit folds upper-case letters onto lower case.
    localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_SEP   = 2'd1;
    localparam logic [1:0] KIND_TERM  = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [NIB_W-1:0] nibble;
    } char_class_t;

    typedef struct packed {
        logic [ADDR_W-1:0] mac_address;
        logic              bad_format;
    } mat_result_t;

endpackage

// File: rtl/mat_char_class.sv
// Character classifier: hex digit, separator, terminator or invalid.
module mat_char_class (
    input  logic [mat_pkg::CHAR_W-1:0] character,
    output mat_pkg::char_class_t       cls
);
    import mat_pkg::*;

    logic [CHAR_W-1:0] folded;

    always_comb begin
        folded     = character | CASE_BIT;
        cls.kind   = KIND_BAD;
        cls.nibble = '0;
        if (character inside {[8'h30:8'h39]}) begin
            cls.kind   = KIND_DIGIT;
            cls.nibble = character[NIB_W-1:0];
        end else if (folded inside {[8'h61:8'h66]}) begin
            // 'a' has low nibble 1, so add nine to reach ten
            cls.kind   = KIND_DIGIT;
            cls.nibble = character[NIB_W-1:0] + NIB_W'(9);
        end else if (character == CHAR_COLON || character == CHAR_DASH) begin
            cls.kind = KIND_SEP;
        end else if (character == CHAR_NUL) begin
            cls.kind = KIND_TERM;
        end
    end

endmodule

// File: rtl/mat_group_acc.sv
// Group and address accumulator: builds groups and folds them into the address.
`include "mac_address_text_parser_macros.svh"

module mat_group_acc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  mat_pkg::char_class_t cls,
    output mat_pkg::mat_result_t res
);
    import mat_pkg::*;

    logic [ADDR_W-1:0] accum_reg, accum_next;
    logic [ADDR_W-1:0] group_reg, group_next;
    logic [GCNT_W-1:0] gcnt_reg, gcnt_next;
    logic [TCNT_W-1:0] tcnt_reg, tcnt_next;
    logic              err_reg, err_next;

    logic [TCNT_W-1:0] pad;
    logic [TCNT_W-1:0] sum;
    logic              over;
    logic [5:0]        shamt;
    logic [ADDR_W-1:0] closed_accum;
    logic [TCNT_W-1:0] closed_tcnt;
    logic              bad;

    always_comb begin
        // Pad odd groups to whole bytes; an empty group is one zero byte.
        if (gcnt_reg == '0) begin
            pad = TCNT_W'(2);
        end else begin
            pad = TCNT_W'(gcnt_reg) + TCNT_W'(gcnt_reg[0]);
        end
        sum          = tcnt_reg + pad;
        over         = sum > TCNT_W'(NIBBLE_LIMIT);
        shamt        = {pad[3:0], 2'b00};
        closed_accum = over ? accum_reg : ((accum_reg << shamt) | group_reg);
        closed_tcnt  = over ? TCNT_W'(COUNT_SAT) : sum;

        bad             = err_reg || over;
        res.bad_format  = bad;
        res.mac_address = bad ? '0 : closed_accum;
    end

    always_comb begin
        accum_next = accum_reg;
        group_next = group_reg;
        gcnt_next  = gcnt_reg;
        tcnt_next  = tcnt_reg;
        err_next   = err_reg;
        if (step) begin
            case (cls.kind)
                KIND_DIGIT: begin
                    group_next = {group_reg[ADDR_W-NIB_W-1:0], cls.nibble};
                    if (gcnt_reg < GCNT_W'(COUNT_SAT)) begin
                        gcnt_next = gcnt_reg + GCNT_W'(1);
                    end
                end
                KIND_SEP: begin
                    accum_next = closed_accum;
                    tcnt_next  = closed_tcnt;
                    group_next = '0;
                    gcnt_next  = '0;
                end
                KIND_BAD: begin
                    err_next = 1'b1;
                end
                KIND_TERM: begin
                    accum_next = '0;
                    group_next = '0;
                    gcnt_next  = '0;
                    tcnt_next  = '0;
                    err_next   = 1'b0;
                end
                default: begin
                    err_next = err_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
            group_reg <= '0;
            gcnt_reg  <= '0;
            tcnt_reg  <= '0;
            err_reg   <= 1'b0;
        end else begin
            accum_reg <= accum_next;
            group_reg <= group_next;
            gcnt_reg  <= gcnt_next;
            tcnt_reg  <= tcnt_next;
            err_reg   <= err_next;
        end
    end

    `MAT_ASSERT_IMPL(a_gcnt_sat, 1'b1, gcnt_reg <= GCNT_W'(COUNT_SAT), "group count past saturation")
    `MAT_ASSERT_IMPL(a_tcnt_sat, 1'b1, tcnt_reg <= TCNT_W'(COUNT_SAT), "total count past saturation")
    `MAT_ASSERT_NEXT(a_term_clear, step && cls.kind == KIND_TERM, accum_reg == '0 && group_reg == '0 && gcnt_reg == '0 && tcnt_reg == '0 && !err_reg, "state not cleared after terminator")

endmodule

// File: rtl/mac_address_text_parser.sv
// MAC address text parser top level: input register, accumulator, result register.
//
// Feed the address text one character per beat on the s_axis channel, ending
// with a zero byte. Each terminator yields one result beat on m_axis: the
// 48-bit address in tdata (first byte in bits 47..40) and bad_format in tuser.
// Other characters yield no result.
// Path: a terminator passes from the input register straight to the result
// register. Throughput: one character per cycle while no terminator waits for
// the result register; the classify and accumulate step sits between the input
// register and the result register.
// Reset (aresetn low, synchronous) empties both registers and clears the
// parser state, so the next character starts a fresh address.
// A stall on m_axis holds the result register; characters that produce no
// result keep flowing. A terminator waits in the input register until the
// result register is free, and s_axis_tready drops while it waits.
`include "mac_address_text_parser_macros.svh"

module mac_address_text_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [mat_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] character
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [mat_pkg::ADDR_W-1:0]  m_axis_tdata,   // [47:0] mac_address
    output logic                        m_axis_tuser    // [0] bad_format
);
    import mat_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg, in_char_next;
    logic              out_valid_reg, out_valid_next;
    mat_result_t       out_data_reg, out_data_next;

    char_class_t cls;
    mat_result_t res;
    logic        is_term;
    logic        out_free;
    logic        step;

    mat_char_class u_class (
        .character (in_char_reg),
        .cls       (cls)
    );

    mat_group_acc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cls     (cls),
        .res     (res)
    );

    always_comb begin
        is_term       = cls.kind == KIND_TERM;
        out_free      = !out_valid_reg || m_axis_tready;
        // Hold a terminator until the result register can take it.
        step          = in_valid_reg && (!is_term || out_free);
        s_axis_tready = !in_valid_reg || step;

        in_valid_next = in_valid_reg;
        in_char_next  = in_char_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
            in_char_next  = s_axis_tdata;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (step && is_term) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_char_reg  <= in_char_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg.mac_address;
    assign m_axis_tuser  = out_data_reg.bad_format;

    `MAT_ASSERT_IMPL(a_bad_zero_addr, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "bad result with nonzero address")
    `MAT_ASSERT_IMPL(a_result_source, $rose(out_valid_reg), $past(step && is_term), "result without terminator")
    `MAT_ASSERT_NEXT(a_in_hold, in_valid_reg && !step, in_valid_reg && $stable(in_char_reg), "stalled character lost")

endmodule
